// File: src/sha1sh_pkg.sv
// Shared types, constants and helper functions for the streaming SHA-1 engine.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package sha1sh_pkg;

  localparam int WORDS      = 5;
  localparam int ROUNDS     = 80;
  localparam int BLK_BITS   = 512;
  localparam int LEN_BITS   = 64;

  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] LAST_BYTE  = 6'd63;
  localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [2:0] LAST_INDEX = 3'(WORDS - 1);

  localparam logic [31:0] INIT_H [WORDS] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  typedef enum logic [1:0] {
    SEL_IN,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      shift_en;
    byte_sel_t sel;
    logic [2:0] len_sel;
    logic      load_vars;
    logic      round_en;
    logic [1:0] stage;
    logic      add_chain;
    logic      finish_load;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  function automatic logic [31:0] round_k(input logic [1:0] stage);
    logic [31:0] k;
    case (stage)
      2'd0:    k = 32'h5a827999;
      2'd1:    k = 32'h6ed9eba1;
      2'd2:    k = 32'h8f1bbcdc;
      default: k = 32'hca62c1d6;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] stage, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (stage)
      2'd0:    f = (b & c) | (~b & d);
      2'd2:    f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

// File: src/sha1sh_ctrl.sv
// Controller for the streaming SHA-1 engine: byte counting, padding sequence,
// round counting and digest hand-off. Depends on sha1sh_pkg.
`default_nettype none
module sha1sh_ctrl import sha1sh_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire logic    command,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LOAD,
    S_ROUND,
    S_ADD,
    S_DONE
  } state_t;

  state_t     state;
  logic [5:0] fill;
  logic [6:0] rnd;
  logic [1:0] stage;
  logic       pad_first;
  logic       len_ok;
  logic       pad_mode;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.sel      = SEL_IN;
    cmd.len_sel  = fill[2:0];
    cmd.stage    = stage;
    case (state)
      S_IDLE: begin
        cmd.shift_en = accept && !command;
      end
      S_PAD: begin
        cmd.shift_en = 1'b1;
        if (pad_first) begin
          cmd.sel = SEL_PAD;
        end else if (len_ok && fill >= LEN_POS) begin
          cmd.sel = SEL_LEN;
        end else begin
          cmd.sel = SEL_ZERO;
        end
      end
      S_LOAD:  cmd.load_vars   = 1'b1;
      S_ROUND: cmd.round_en    = 1'b1;
      S_ADD:   cmd.add_chain   = 1'b1;
      S_DONE:  cmd.finish_load = !status.out_busy;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      rnd       <= '0;
      stage     <= '0;
      pad_first <= 1'b0;
      len_ok    <= 1'b0;
      pad_mode  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!command) begin
              fill <= fill + 6'd1;
              if (fill == LAST_BYTE) begin
                state <= S_LOAD;
              end
            end else begin
              pad_mode  <= 1'b1;
              pad_first <= 1'b1;
              len_ok    <= (fill < LEN_POS);
              state     <= S_PAD;
            end
          end
        end
        S_PAD: begin
          pad_first <= 1'b0;
          fill      <= fill + 6'd1;
          if (fill == LAST_BYTE) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          rnd   <= '0;
          stage <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          rnd <= rnd + 7'd1;
          if (rnd == 7'd19 || rnd == 7'd39 || rnd == 7'd59) begin
            stage <= stage + 2'd1;
          end
          if (rnd == LAST_ROUND) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (pad_mode && len_ok) begin
            state <= S_DONE;
          end else if (pad_mode) begin
            len_ok <= 1'b1;
            state  <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DONE: begin
          if (!status.out_busy) begin
            pad_mode <= 1'b0;
            len_ok   <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/sha1sh_datapath.sv
// Datapath for the streaming SHA-1 engine: block shift line and message
// schedule, round variables, chaining value, bit count and digest output.
// Depends on sha1sh_pkg.
`default_nettype none
module sha1sh_datapath import sha1sh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  message_byte,
  input  wire cmd_t        cmd,
  output status_t          status,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  logic [BLK_BITS-1:0] blk;
  logic [LEN_BITS-1:0] bits;
  logic [31:0]         chain [WORDS];
  logic [31:0]         va, vb, vc, vd, ve;
  logic [31:0]         outw  [WORDS];
  logic [2:0]          out_idx;

  logic [7:0]  byte_next;
  logic [2:0]  len_pos;
  logic [31:0] w0, w2, w8, w13, w_mix, w_new, tmp;
  logic        out_take;

  assign len_pos = 3'd7 - cmd.len_sel;

  always_comb begin
    case (cmd.sel)
      SEL_IN:   byte_next = message_byte;
      SEL_PAD:  byte_next = PAD_BYTE;
      SEL_LEN:  byte_next = bits[{len_pos, 3'b000} +: 8];
      default:  byte_next = 8'h00;
    endcase
  end

  assign w0    = blk[511:480];
  assign w2    = blk[447:416];
  assign w8    = blk[255:224];
  assign w13   = blk[95:64];
  assign w_mix = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign tmp   = {va[26:0], va[31:27]} + round_f(cmd.stage, vb, vc, vd) + ve
                 + round_k(cmd.stage) + w0;

  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      blk <= {blk[BLK_BITS-9:0], byte_next};
    end else if (cmd.round_en) begin
      blk <= {blk[BLK_BITS-33:0], w_new};
    end
    if (cmd.load_vars) begin
      va <= chain[0];
      vb <= chain[1];
      vc <= chain[2];
      vd <= chain[3];
      ve <= chain[4];
    end else if (cmd.round_en) begin
      va <= tmp;
      vb <= va;
      vc <= {vb[1:0], vb[31:2]};
      vd <= vc;
      ve <= vd;
    end
    if (cmd.finish_load) begin
      for (int i = 0; i < WORDS; i++) begin
        outw[i] <= chain[i];
      end
    end else if (out_take) begin
      for (int i = 0; i < WORDS - 1; i++) begin
        outw[i] <= outw[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits <= '0;
      for (int i = 0; i < WORDS; i++) begin
        chain[i] <= INIT_H[i];
      end
    end else begin
      if (cmd.finish_load) begin
        bits <= '0;
        for (int i = 0; i < WORDS; i++) begin
          chain[i] <= INIT_H[i];
        end
      end else begin
        if (cmd.shift_en && cmd.sel == SEL_IN) begin
          bits <= bits + 64'd8;
        end
        if (cmd.add_chain) begin
          chain[0] <= chain[0] + va;
          chain[1] <= chain[1] + vb;
          chain[2] <= chain[2] + vc;
          chain[3] <= chain[3] + vd;
          chain[4] <= chain[4] + ve;
        end
      end
    end
  end

  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_idx   <= '0;
    end else if (cmd.finish_load) begin
      out_valid <= 1'b1;
      out_idx   <= '0;
    end else if (out_take) begin
      out_idx <= out_idx + 3'd1;
      if (out_idx == LAST_INDEX) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.out_busy = out_valid;
  assign digest_word     = outw[0];
  assign word_index      = out_idx;
  assign last_word       = (out_idx == LAST_INDEX);

endmodule
`default_nettype wire

// File: src/sha1_stream_hash_top.sv
// Top level of the streaming SHA-1 engine: joins controller and datapath.
// Depends on sha1sh_pkg, sha1sh_ctrl and sha1sh_datapath.
//
//   channel   handshake              payload
//   input     in_valid / in_ready    command, message_byte
//   output    out_valid / out_ready  digest_word, word_index, last_word
//
// Message bytes come in one per cycle while in_ready is high; a byte ending a
// 64-byte block starts load, 80 rounds on the single round unit, chain add.
// Finish shifts in one pad byte a cycle up to the block end, runs one or two
// compressions, then waits for the digest register to be free and loads it.
// Digest words leave one per cycle on out_ready; bytes may enter meanwhile.
// Reset restores the initial chaining value at once; no clearing pass.
`default_nettype none
module sha1_stream_hash_top import sha1sh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command,
  input  wire logic [7:0]  message_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  cmd_t    cmd;
  status_t status;

  sha1sh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .status   (status),
    .cmd      (cmd)
  );

  sha1sh_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .message_byte (message_byte),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word)
  );

endmodule
`default_nettype wire
